[rtl/sdrf_pkg.sv]
// Shared constants, codes and types of the shake detector rate filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sdrf_pkg;

  localparam int AXIS_W        = 16;
  localparam int TIME_W        = 32;
  localparam int DEV_W         = 16;
  localparam int THR_W         = 15;
  localparam int CNT_W         = 4;
  localparam int RATE_W        = 26;
  localparam int MODE_W        = 2;
  localparam int TDATA_W       = 128;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TUSER_W   = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam int SUM_W         = 32;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int REM_W         = ROOT_W + 2;
  localparam int ROOT_STEPS    = ROOT_W;
  localparam int STEP_CNT_W    = $clog2(ROOT_STEPS);

  localparam int FRAC_BITS       = 8;
  localparam int ALPHA_NUMERATOR = 77;
  localparam int ALPHA_SHIFT     = 8;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_IDX_W      = $clog2(NUM_AXES);
  localparam int FILT_STEPS      = 2 * NUM_AXES;
  localparam int SAMPLE_W        = AXIS_W + 1 + FRAC_BITS;
  localparam int DIFF_W          = ((SAMPLE_W > RATE_W) ? SAMPLE_W : RATE_W) + 1;
  localparam int COEF_W          = 9;
  localparam int PROD_W          = DIFF_W + COEF_W;
  localparam int NEXT_W          = PROD_W + 2;

  localparam logic signed [COEF_W-1:0] ALPHA_COEF = COEF_W'(ALPHA_NUMERATOR);
  localparam logic signed [NEXT_W-1:0] ROUND_HALF = NEXT_W'(1 << (ALPHA_SHIFT - 1));
  localparam logic signed [NEXT_W-1:0] RATE_HI    = NEXT_W'((1 << (RATE_W - 1)) - 1);
  localparam logic signed [NEXT_W-1:0] RATE_LO    = -RATE_HI - NEXT_W'(1);

  localparam logic [CNT_W-1:0] OVER_MAX = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [MODE_W-1:0] MODE_ERROR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STILL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHAKE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REST_BASELINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BIAS_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BIAS_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BIAS_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TICKS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_MS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIME_MS = 3'd7;

  localparam int OUT_ACTIVE_BIT  = DEV_W;
  localparam int OUT_CHANGED_BIT = DEV_W + 1;

  typedef struct packed {
    logic [DEV_W-1:0]         rest_baseline;
    logic [THR_W-1:0]         shake_threshold;
    logic signed [AXIS_W-1:0] rate_bias_x;
    logic signed [AXIS_W-1:0] rate_bias_y;
    logic signed [AXIS_W-1:0] rate_bias_z;
    logic [CNT_W-1:0]         confirm_ticks;
    logic [DEV_W-1:0]         hold_time_ms;
    logic [DEV_W-1:0]         release_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]        time_ms;
    logic signed [AXIS_W-1:0] rot_z;
    logic signed [AXIS_W-1:0] rot_y;
    logic signed [AXIS_W-1:0] rot_x;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_x;
  } in_data_t;

  typedef struct packed {
    logic [SUM_W-1:0]         sum_sq;
    logic                     accel_valid;
    logic                     rot_valid;
    logic signed [AXIS_W-1:0] rot_x;
    logic signed [AXIS_W-1:0] rot_y;
    logic signed [AXIS_W-1:0] rot_z;
    logic [TIME_W-1:0]        time_ms;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]        last_shake_time;
    logic signed [RATE_W-1:0] yaw_rate;
    logic signed [RATE_W-1:0] roll_rate;
    logic signed [RATE_W-1:0] pitch_rate;
    logic                     active_changed;
    logic                     shake_active;
    logic [DEV_W-1:0]         deviation;
  } result_t;

endpackage

`default_nettype wire

[rtl/sdrf_front.sv]
// Front end: accepts sensor ticks and forms the sum of accelerometer squares
// with one shared multiplier, then hands the tick to the queue. Uses sdrf_pkg.
`default_nettype none

module sdrf_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sdrf_pkg::TDATA_W-1:0]     s_axis_tdata,
  input  logic [sdrf_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             push,
  output sdrf_pkg::item_t                  push_item,
  input  logic                             q_full
);
  import sdrf_pkg::*;

  localparam logic [1:0] STEP_DONE = 2'd3;

  in_data_t                 din;
  logic                     busy;
  logic [1:0]               step;
  logic signed [AXIS_W-1:0] ax, ay, az;
  logic signed [AXIS_W-1:0] sq_in;
  logic signed [SUM_W-1:0]  sq;
  logic [SUM_W-1:0]         acc;
  logic                     accel_valid, rot_valid;
  logic signed [AXIS_W-1:0] rot_x, rot_y, rot_z;
  logic [TIME_W-1:0]        time_ms;
  logic                     accept;

  assign din           = in_data_t'(s_axis_tdata);
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  assign push          = busy && (step == STEP_DONE) && !q_full;

  always_comb begin
    case (step)
      2'd0:    sq_in = ax;
      2'd1:    sq_in = ay;
      default: sq_in = az;
    endcase
    sq = sq_in * sq_in;
  end

  always_comb begin
    push_item.sum_sq      = acc;
    push_item.accel_valid = accel_valid;
    push_item.rot_valid   = rot_valid;
    push_item.rot_x       = rot_x;
    push_item.rot_y       = rot_y;
    push_item.rot_z       = rot_z;
    push_item.time_ms     = time_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy && step != STEP_DONE) begin
      step <= step + 2'd1;
    end else if (push) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax          <= din.accel_x;
      ay          <= din.accel_y;
      az          <= din.accel_z;
      rot_x       <= din.rot_x;
      rot_y       <= din.rot_y;
      rot_z       <= din.rot_z;
      time_ms     <= din.time_ms;
      accel_valid <= s_axis_tuser[0];
      rot_valid   <= s_axis_tuser[1];
      acc         <= '0;
    end else if (busy && step != STEP_DONE) begin
      acc <= acc + $unsigned(sq);
    end
  end

endmodule

`default_nettype wire

[rtl/sdrf_queue.sv]
// Two-entry queue between the front end and the back end.
// Holds sdrf_pkg::item_t entries; uses sdrf_pkg.
`default_nettype none

module sdrf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sdrf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output sdrf_pkg::item_t pop_item,
  output logic            empty
);
  import sdrf_pkg::*;

  item_t             slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sdrf_back.sv]
// Back end: iterative square root, deviation, shake confirmation, hold and
// release timing, rate filters and the output register. Uses sdrf_pkg.
`default_nettype none

module sdrf_back (
  input  logic                             clk,
  input  logic                             rst,
  input  sdrf_pkg::cfg_t                   cfg,
  input  logic                             q_empty,
  input  sdrf_pkg::item_t                  q_item,
  output logic                             pop,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sdrf_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic [sdrf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import sdrf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DEV  = 2'd2;
  localparam logic [1:0] ST_EVAL = 2'd3;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP  = STEP_CNT_W'(ROOT_STEPS - 1);
  localparam logic [STEP_CNT_W-1:0] FILT_LIMIT = STEP_CNT_W'(FILT_STEPS);

  logic [1:0]            st;
  logic [STEP_CNT_W-1:0] cnt;
  item_t                 cur;
  logic [SUM_W-1:0]      x;
  logic [REM_W-1:0]      rem;
  logic [ROOT_W-1:0]     root;
  logic [DEV_W-1:0]      dev;

  logic [MODE_W-1:0]     mode;
  logic [CNT_W-1:0]      over_count;
  logic [TIME_W-1:0]     confirm_time;
  logic [TIME_W-1:0]     recent_shake_time;
  logic                  active_flag;
  logic [DEV_W-1:0]      last_deviation;
  logic signed [RATE_W-1:0] filt [NUM_AXES];

  logic                  out_valid;
  result_t               out_data;
  logic [MODE_W-1:0]     out_mode;
  logic                  out_free;
  logic                  load;

  // square root step
  logic [REM_W+1:0]      shifted, trial;
  logic                  ge;

  always_comb begin
    shifted = {rem, x[SUM_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    ge      = (shifted >= trial);
  end

  // filter datapath
  logic [AXIS_IDX_W-1:0]    axis;
  logic                     filt_en, filt_mul;
  logic signed [AXIS_W-1:0] raw, bias;
  logic signed [AXIS_W:0]   centered;
  logic signed [SAMPLE_W-1:0] samp;
  logic signed [RATE_W-1:0] f_cur;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [NEXT_W-1:0] rounded, f_sum;
  logic signed [RATE_W-1:0] f_sat;

  always_comb begin
    case (cnt[2:1])
      2'd0:    axis = AXIS_IDX_W'(0);
      2'd1:    axis = AXIS_IDX_W'(1);
      default: axis = AXIS_IDX_W'(2);
    endcase
    case (axis)
      AXIS_IDX_W'(0): begin
        raw  = cur.rot_x;
        bias = cfg.rate_bias_x;
      end
      AXIS_IDX_W'(1): begin
        raw  = cur.rot_y;
        bias = cfg.rate_bias_y;
      end
      default: begin
        raw  = cur.rot_z;
        bias = cfg.rate_bias_z;
      end
    endcase
    filt_en  = (st == ST_SQRT) && cur.rot_valid && (cnt < FILT_LIMIT);
    filt_mul = !cnt[0];
    f_cur    = filt[axis];
    centered = {raw[AXIS_W-1], raw} - {bias[AXIS_W-1], bias};
    samp     = {centered, {FRAC_BITS{1'b0}}};
    diff     = DIFF_W'(samp) - DIFF_W'(f_cur);
    rounded  = (NEXT_W'(prod) + ROUND_HALF) >>> ALPHA_SHIFT;
    f_sum    = NEXT_W'(f_cur) + rounded;
    if (f_sum > RATE_HI) begin
      f_sat = RATE_HI[RATE_W-1:0];
    end else if (f_sum < RATE_LO) begin
      f_sat = RATE_LO[RATE_W-1:0];
    end else begin
      f_sat = f_sum[RATE_W-1:0];
    end
  end

  // decision
  logic                  over;
  logic [CNT_W-1:0]      oc_inc;
  logic [MODE_W-1:0]     mode_next;
  logic [CNT_W-1:0]      over_count_next;
  logic [TIME_W-1:0]     confirm_time_next;
  logic [TIME_W-1:0]     recent_next;
  logic                  active_next;
  logic                  changed;
  logic [DEV_W-1:0]      last_dev_next;

  always_comb begin
    over              = (dev >= {1'b0, cfg.shake_threshold});
    oc_inc            = (over_count < OVER_MAX) ? over_count + CNT_W'(1) : over_count;
    mode_next         = mode;
    over_count_next   = over_count;
    confirm_time_next = confirm_time;
    last_dev_next     = last_deviation;
    if (cur.accel_valid) begin
      last_dev_next = dev;
      if (over) begin
        over_count_next = oc_inc;
        if (oc_inc >= cfg.confirm_ticks) begin
          confirm_time_next = cur.time_ms;
          mode_next         = MODE_SHAKE;
        end
      end else begin
        over_count_next = '0;
        mode_next = ((cur.time_ms - confirm_time) < TIME_W'(cfg.hold_time_ms)) ?
                    MODE_SHAKE : MODE_STILL;
      end
    end else begin
      mode_next = MODE_ERROR;
    end

    recent_next = recent_shake_time;
    active_next = active_flag;
    changed     = 1'b0;
    if (mode_next == MODE_SHAKE) begin
      recent_next = cur.time_ms;
      if (!active_flag) begin
        active_next = 1'b1;
        changed     = 1'b1;
      end
    end else if (active_flag &&
                 ((cur.time_ms - recent_shake_time) > TIME_W'(cfg.release_time_ms))) begin
      active_next = 1'b0;
      changed     = 1'b1;
    end
  end

  assign out_free      = !out_valid || m_axis_tready;
  assign pop           = (st == ST_IDLE) && !q_empty;
  assign load          = (st == ST_EVAL) && out_free;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_IDLE;
      cnt <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (pop) begin
            st  <= ST_SQRT;
            cnt <= '0;
          end
        end
        ST_SQRT: begin
          cnt <= cnt + STEP_CNT_W'(1);
          if (cnt == LAST_STEP) begin
            st <= ST_DEV;
          end
        end
        ST_DEV: begin
          st <= ST_EVAL;
        end
        ST_EVAL: begin
          if (load) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= q_item;
      x    <= q_item.sum_sq;
      rem  <= '0;
      root <= '0;
    end else if (st == ST_SQRT) begin
      x    <= {x[SUM_W-3:0], 2'b00};
      rem  <= ge ? REM_W'(shifted - trial) : shifted[REM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
    if (st == ST_DEV) begin
      dev <= (root >= cfg.rest_baseline) ? root - cfg.rest_baseline
                                         : cfg.rest_baseline - root;
    end
    if (filt_en && filt_mul) begin
      prod <= diff * ALPHA_COEF;
    end
    if (load) begin
      out_mode                 <= mode_next;
      out_data.deviation       <= last_dev_next;
      out_data.shake_active    <= active_next;
      out_data.active_changed  <= changed;
      out_data.pitch_rate      <= filt[0];
      out_data.roll_rate       <= filt[1];
      out_data.yaw_rate        <= filt[2];
      out_data.last_shake_time <= recent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_STILL;
      over_count        <= '0;
      confirm_time      <= '0;
      recent_shake_time <= '0;
      active_flag       <= 1'b0;
      last_deviation    <= '0;
      out_valid         <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        filt[i] <= '0;
      end
    end else begin
      if (filt_en && !filt_mul) begin
        filt[axis] <= f_sat;
      end
      if (load) begin
        mode              <= mode_next;
        over_count        <= over_count_next;
        confirm_time      <= confirm_time_next;
        recent_shake_time <= recent_next;
        active_flag       <= active_next;
        last_deviation    <= last_dev_next;
        out_valid         <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/shake_detector_rate_filter.sv]
// Top level of the shake detector rate filter: configuration registers,
// front end, queue and back end. Uses sdrf_pkg, sdrf_front, sdrf_queue, sdrf_back.
//
// One result leaves for every tick taken in. The back end works on one tick at
// a time: a pop, a 16-step square root (one result bit a cycle), a deviation
// step and a decision step that waits while the output register is full; the
// rate filters run alongside the root. The front end takes no new tick while it
// forms the sum of squares on one multiplier or waits for room in the queue,
// and a two-entry queue lets it run ahead of the back end. Configuration writes
// are always ready and take effect at once; write them only while no tick is in
// flight.
`default_nettype none

module shake_detector_rate_filter (
  input  logic                             clk,
  input  logic                             rst,
  // accel_x, accel_y, accel_z, rot_x, rot_y, rot_z, time_ms
  input  logic [sdrf_pkg::TDATA_W-1:0]     s_axis_tdata,
  // accel_valid, rot_valid
  input  logic [sdrf_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // deviation, shake_active, active_changed, pitch_rate, roll_rate,
  // yaw_rate, last_shake_time
  output logic [sdrf_pkg::TDATA_W-1:0]     m_axis_tdata,
  // motion_state
  output logic [sdrf_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sdrf_pkg::*;

  cfg_t  cfg;
  item_t push_item, pop_item;
  logic  push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest_baseline   <= 16'd16384;
      cfg.shake_threshold <= 15'd819;
      cfg.rate_bias_x     <= '0;
      cfg.rate_bias_y     <= '0;
      cfg.rate_bias_z     <= '0;
      cfg.confirm_ticks   <= 4'd3;
      cfg.hold_time_ms    <= 16'd2000;
      cfg.release_time_ms <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REST_BASELINE:   cfg.rest_baseline   <= cfg_data;
        CFG_SHAKE_THRESHOLD: cfg.shake_threshold <= cfg_data[THR_W-1:0];
        CFG_RATE_BIAS_X:     cfg.rate_bias_x     <= cfg_data;
        CFG_RATE_BIAS_Y:     cfg.rate_bias_y     <= cfg_data;
        CFG_RATE_BIAS_Z:     cfg.rate_bias_z     <= cfg_data;
        CFG_CONFIRM_TICKS:   cfg.confirm_ticks   <= cfg_data[CNT_W-1:0];
        CFG_HOLD_TIME_MS:    cfg.hold_time_ms    <= cfg_data;
        CFG_RELEASE_TIME_MS: cfg.release_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  sdrf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .push_item     (push_item),
    .q_full        (q_full)
  );

  sdrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  sdrf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

[rtl/sdrf_checker.sv]
// Port-level checks of the shake detector rate filter and their binding.
// Uses sdrf_pkg; attaches to shake_detector_rate_filter.
`default_nettype none

module sdrf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sdrf_pkg::TDATA_W-1:0]     m_axis_tdata,
  input logic [sdrf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import sdrf_pkg::*;

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  a_shake_active: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == MODE_SHAKE) |-> m_axis_tdata[OUT_ACTIVE_BIT])
    else $error("shake state without active flag");

  a_release: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != MODE_SHAKE) && m_axis_tdata[OUT_CHANGED_BIT]
      |-> !m_axis_tdata[OUT_ACTIVE_BIT])
    else $error("active flag set outside shake state");

endmodule

bind shake_detector_rate_filter sdrf_checker u_sdrf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
